// ===== rtl/oit_pkg.sv =====
// ----------------------------------------------------------------------------
// oit_pkg
// Shared types and constants for the ordered id table: the capacity, the
// operation and status codes, the transaction structs and the cell types.
// ----------------------------------------------------------------------------
package oit_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ID_W     = 16;
   localparam int PAY_W    = 32;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_REMOVE = 2'd1,
      OP_POP    = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   typedef struct packed {
      op_type             operation;
      logic [ID_W-1:0]    entry_id;
      logic [PAY_W-1:0]   entry_payload;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [3:0]         found_index;
      logic [PAY_W-1:0]   found_payload;
      logic [4:0]         entry_count;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PAY_W-1:0]   payload;
   } entry_type;

   typedef struct packed {
      logic compare;
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

// ===== rtl/oit_cell.sv =====
// ----------------------------------------------------------------------------
// oit_cell
// One table slot: holds an id and payload, takes a new entry on load or its
// upper neighbour's entry on shift, and registers an id compare flag.
// ----------------------------------------------------------------------------
module oit_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  oit_pkg::cell_ctrl_type    ctrl,
   input  logic                      occupied,
   input  logic [oit_pkg::ID_W-1:0]  key,
   input  oit_pkg::entry_type        load_entry,
   input  oit_pkg::entry_type        next_entry,
   output oit_pkg::entry_type        entry,
   output logic                      match
);

   oit_pkg::entry_type entry_ff, entry_in;
   logic               match_ff, match_in;

   always_comb begin
      priority if (ctrl.load) begin
         entry_in = load_entry;
      end else if (ctrl.shift) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   // hold the flag until the next transaction is accepted
   assign match_in = ctrl.compare ? (occupied && (entry_ff.id == key)) : match_ff;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ===== rtl/oit_pick.sv =====
// ----------------------------------------------------------------------------
// oit_pick
// Resolve the first matching cell: one-hot select, mask of the cells below it,
// encoded position and the selected payload.
// ----------------------------------------------------------------------------
module oit_pick (
   input  logic [oit_pkg::CAPACITY-1:0]  match,
   input  oit_pkg::entry_type            entries [oit_pkg::CAPACITY],
   output logic                          hit,
   output logic [oit_pkg::CAPACITY-1:0]  below,
   output logic [oit_pkg::IDX_W-1:0]     index,
   output logic [oit_pkg::PAY_W-1:0]     payload
);

   logic [oit_pkg::CAPACITY-1:0] first;

   // isolate the lowest set bit
   assign first = match & (~match + oit_pkg::CAPACITY'(1));
   assign hit   = |match;
   assign below = first - oit_pkg::CAPACITY'(1);

   always_comb begin
      index   = '0;
      payload = '0;
      for (int i = 0; i < oit_pkg::CAPACITY; i++) begin
         if (first[i]) begin
            index = index | oit_pkg::IDX_W'(i);
         end
         payload = payload | ({oit_pkg::PAY_W{first[i]}} & entries[i].payload);
      end
   end

endmodule

// ===== rtl/ordered_id_table.sv =====
// ----------------------------------------------------------------------------
// ordered_id_table
// Ordered table of id/payload entries held in a row of cells.
// A start is taken only in idle, when the cells register their compare flags;
// the exec state (shift/update) registers the result; no start is taken then.
// busy is high in the update cycle only; the result strobe cannot be stalled.
// Reset empties the table; no clearing pass, start is taken at once.
// ----------------------------------------------------------------------------
module ordered_id_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  oit_pkg::req_type  req_item,
   output logic              rsp_strobe,
   output oit_pkg::rsp_type  rsp_item
);

   localparam int CAP = oit_pkg::CAPACITY;

   oit_pkg::fsm_type              state_ff, state_in;
   oit_pkg::req_type              req_ff, req_in;
   logic [oit_pkg::CNT_W-1:0]     count_ff, count_in;
   oit_pkg::rsp_type              rsp_ff, rsp_in;
   logic                          strobe_ff, strobe_in;

   oit_pkg::cell_ctrl_type        ctrl [CAP];
   oit_pkg::entry_type            entries [CAP];
   logic [CAP-1:0]                match;
   logic [CAP-1:0]                occupied;

   logic                          hit;
   logic [CAP-1:0]                below;
   logic [oit_pkg::IDX_W-1:0]     hit_index;
   logic [oit_pkg::PAY_W-1:0]     hit_payload;

   logic                          accept;
   logic                          full;
   logic                          empty;
   oit_pkg::entry_type            new_entry;

   assign accept    = start && (state_ff == oit_pkg::FSM_IDLE);
   assign full      = (count_ff == oit_pkg::CNT_W'(CAP));
   assign empty     = (count_ff == '0);
   assign new_entry = '{id: req_ff.entry_id, payload: req_ff.entry_payload};

   genvar g;
   generate
      for (g = 0; g < CAP; g++) begin : g_cell
         assign occupied[g] = (oit_pkg::CNT_W'(g) < count_ff);

         oit_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl[g]),
            .occupied   (occupied[g]),
            .key        (req_item.entry_id),
            .load_entry (new_entry),
            .next_entry ((g == CAP - 1) ? entries[g] : entries[(g + 1) % CAP]),
            .entry      (entries[g]),
            .match      (match[g])
         );
      end
   endgenerate

   oit_pick u_pick (
      .match   (match),
      .entries (entries),
      .hit     (hit),
      .below   (below),
      .index   (hit_index),
      .payload (hit_payload)
   );

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      count_in  = count_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      for (int i = 0; i < CAP; i++) begin
         ctrl[i] = '{compare: accept, load: 1'b0, shift: 1'b0};
      end

      unique case (state_ff)
         oit_pkg::FSM_IDLE: begin
            if (accept) begin
               req_in   = req_item;
               state_in = oit_pkg::FSM_EXEC;
            end
         end
         oit_pkg::FSM_EXEC: begin
            state_in             = oit_pkg::FSM_IDLE;
            strobe_in            = 1'b1;
            rsp_in.status        = oit_pkg::ST_OK;
            rsp_in.found_index   = '0;
            rsp_in.found_payload = '0;
            unique case (req_ff.operation)
               oit_pkg::OP_APPEND: begin
                  if (full) begin
                     rsp_in.status = oit_pkg::ST_FULL;
                  end else begin
                     for (int i = 0; i < CAP; i++) begin
                        ctrl[i].load = (oit_pkg::CNT_W'(i) == count_ff);
                     end
                     count_in = count_ff + oit_pkg::CNT_W'(1);
                  end
               end
               oit_pkg::OP_REMOVE: begin
                  if (empty) begin
                     rsp_in.status = oit_pkg::ST_EMPTY;
                  end else if (!hit) begin
                     rsp_in.status = oit_pkg::ST_NOT_FOUND;
                  end else begin
                     // close the gap: every cell from the match upward advances
                     for (int i = 0; i < CAP; i++) begin
                        ctrl[i].shift = !below[i];
                     end
                     rsp_in.found_index = 4'(hit_index);
                     count_in           = count_ff - oit_pkg::CNT_W'(1);
                  end
               end
               oit_pkg::OP_POP: begin
                  if (empty) begin
                     rsp_in.status = oit_pkg::ST_EMPTY;
                  end else begin
                     for (int i = 0; i < CAP; i++) begin
                        ctrl[i].shift = 1'b1;
                     end
                     count_in = count_ff - oit_pkg::CNT_W'(1);
                  end
               end
               oit_pkg::OP_LOOKUP: begin
                  if (!hit) begin
                     rsp_in.status = oit_pkg::ST_NOT_FOUND;
                  end else begin
                     rsp_in.found_index   = 4'(hit_index);
                     rsp_in.found_payload = hit_payload;
                  end
               end
               default: begin
                  rsp_in.status = oit_pkg::ST_OK;
               end
            endcase
            rsp_in.entry_count = 5'(count_in);
         end
         default: begin
            state_in = oit_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= oit_pkg::FSM_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff == oit_pkg::FSM_EXEC);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
